FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mch_pkg.sv
// ---------------------------------------------------------------------------
// mch_pkg
// Types and constants shared by the coverage histogram modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mch_pkg;

    // Widths of the fixed payload fields.
    localparam int CMD_W      = 2;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int OUT_CNT_W  = 32;

    // Length register value after reset.
    localparam logic [LEN_W-1:0] SEQ_LEN_RESET = 13'd4096;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_RANGE    = 2'd1,
        CMD_MUTATION = 2'd2,
        CMD_READOUT  = 2'd3
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_RANGE,
        BK_MUT,
        BK_DRAIN,
        BK_READ,
        BK_OUT
    } back_state_t;

    // One input beat.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] range_end;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [POS_W-1:0]     read_position;
        logic [OUT_CNT_W-1:0] mutation_count;
        logic [OUT_CNT_W-1:0] coverage_count;
    } result_t;

    // Classified operation passed from front to back.
    typedef struct packed {
        cmd_t             kind;
        logic             zero;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] stop;
    } op_t;

    // Status the back reports to the front.
    typedef struct packed {
        logic init_done;
    } back_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mch_stream_if.sv
// ---------------------------------------------------------------------------
// mch_stream_if
// Valid/ready channel carrying one payload per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface mch_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mch_ram.sv
// ---------------------------------------------------------------------------
// mch_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/mch_queue.sv
// ---------------------------------------------------------------------------
// mch_queue
// Short FIFO of classified operations between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module mch_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire mch_pkg::op_t push_op,
    output      logic         full,
    input  wire logic         pop,
    output      mch_pkg::op_t head_op,
    output      logic         empty
);
    import mch_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    op_t             slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full    = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mch_front.sv
// ---------------------------------------------------------------------------
// mch_front
// Accepts input beats, holds the length register and classifies commands.
// ---------------------------------------------------------------------------
`default_nettype none

module mch_front #(
    parameter int MAX_POSITIONS = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mch_stream_if.sink                 item,
    mch_stream_if.sink                 cfg,
    input  wire mch_pkg::back_status_t status,
    input  wire logic                  queue_full,
    output      logic                  push,
    output      mch_pkg::op_t          push_op
);
    import mch_pkg::*;

    localparam logic [16:0] MaxPos = 17'(MAX_POSITIONS);

    logic [LEN_W-1:0] seq_len_reg;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] end_clip;
    logic [LEN_W-1:0] pos_ext;
    logic             pos_in_range;
    logic             keep;
    item_t            beat;

    assign beat = item.payload;

    // Length register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SEQ_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            seq_len_reg <= cfg.payload;
        end
    end

    // Effective length is the register clipped to the store depth.
    assign len_eff = ({4'b0000, seq_len_reg} > MaxPos) ? MaxPos[LEN_W-1:0] : seq_len_reg;

    assign pos_ext      = {1'b0, beat.position};
    assign pos_in_range = (pos_ext < len_eff);
    assign end_clip     = (beat.range_end > len_eff) ? len_eff : beat.range_end;

    // Classify the beat; commands that change nothing are dropped here.
    always_comb
    begin
        push_op.kind  = cmd_t'(beat.command);
        push_op.zero  = !pos_in_range;
        push_op.start = beat.position;
        push_op.stop  = end_clip;
        unique case (cmd_t'(beat.command))
            CMD_CLEAR:    keep = 1'b1;
            CMD_RANGE:    keep = (end_clip > pos_ext);
            CMD_MUTATION: keep = pos_in_range;
            CMD_READOUT:  keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    // Input is held off during the power-up clearing pass or when the queue is full.
    assign item.ready = status.init_done && !queue_full;
    assign push       = item.valid && item.ready && keep;

endmodule

`default_nettype wire

FILE: rtl/core/mch_back.sv
// ---------------------------------------------------------------------------
// mch_back
// Executes classified operations on the two counter stores.
// ---------------------------------------------------------------------------
`default_nettype none

module mch_back #(
    parameter int MAX_POSITIONS = 4096,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mch_pkg::op_t  head_op,
    input  wire logic          queue_empty,
    output      logic          pop,
    output      mch_pkg::back_status_t status,
    mch_stream_if.source       result
);
    import mch_pkg::*;

    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int CW = (AW > LEN_W) ? AW : LEN_W;

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    op_t               op_reg, op_next;
    logic              init_done_reg, init_done_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_mut_reg, pend_mut_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  mut_wr_en, cov_wr_en;
    logic [COUNT_BITS-1:0] mut_wr_data, cov_wr_data;
    logic [COUNT_BITS-1:0] mut_rd_data, cov_rd_data;
    logic                  range_last;
    logic                  sweep_last;
    logic                  out_free;

    // Counter stores.
    mch_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_POSITIONS)) u_mut_ram (
        .clk     (clk),
        .wr_en   (mut_wr_en),
        .wr_addr (wr_addr),
        .wr_data (mut_wr_data),
        .rd_addr (rd_addr),
        .rd_data (mut_rd_data)
    );

    mch_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_POSITIONS)) u_cov_ram (
        .clk     (clk),
        .wr_en   (cov_wr_en),
        .wr_addr (wr_addr),
        .wr_data (cov_wr_data),
        .rd_addr (rd_addr),
        .rd_data (cov_rd_data)
    );

    assign range_last = ((cnt_reg + 1'b1) == CW'(op_reg.stop));
    assign sweep_last = (cnt_reg == CW'(MAX_POSITIONS - 1));
    assign out_free   = !out_valid_reg || result.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    unique case (head_op.kind)
                        CMD_CLEAR:    state_next = BK_SWEEP;
                        CMD_RANGE:    state_next = BK_RANGE;
                        CMD_MUTATION: state_next = BK_MUT;
                        CMD_READOUT:  state_next = BK_READ;
                        default:      state_next = BK_IDLE;
                    endcase
                end
            end
            BK_RANGE:
            begin
                if (range_last)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_MUT:   state_next = BK_DRAIN;
            BK_DRAIN: state_next = BK_IDLE;
            BK_READ:  state_next = BK_OUT;
            BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // Datapath control per state.
    always_comb
    begin
        pop             = 1'b0;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        init_done_next  = init_done_reg;
        pend_valid_next = 1'b0;
        pend_mut_next   = 1'b0;
        pend_addr_next  = pend_addr_reg;
        rd_addr         = AW'(op_reg.start);
        out_valid_next  = out_valid_reg && !result.ready;
        out_next        = out_reg;
        unique case (state_reg)
            BK_SWEEP:
            begin
                cnt_next = sweep_last ? '0 : cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    init_done_next = 1'b1;
                end
            end
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop      = 1'b1;
                    op_next  = head_op;
                    cnt_next = (head_op.kind == CMD_RANGE) ? CW'(head_op.start) : '0;
                end
            end
            BK_RANGE:
            begin
                rd_addr         = AW'(cnt_reg);
                pend_valid_next = 1'b1;
                pend_addr_next  = AW'(cnt_reg);
                cnt_next        = cnt_reg + 1'b1;
            end
            BK_MUT:
            begin
                pend_valid_next = 1'b1;
                pend_mut_next   = 1'b1;
                pend_addr_next  = AW'(op_reg.start);
            end
            BK_DRAIN:
            begin
            end
            BK_READ:
            begin
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.read_position = op_reg.start;
                    out_next.mutation_count = op_reg.zero ? '0 : OUT_CNT_W'(mut_rd_data);
                    out_next.coverage_count = op_reg.zero ? '0 : OUT_CNT_W'(cov_rd_data);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Write port: clearing pass, or saturating increment in the cycle after the read.
    always_comb
    begin
        if (state_reg == BK_SWEEP)
        begin
            wr_addr     = AW'(cnt_reg);
            mut_wr_en   = 1'b1;
            cov_wr_en   = 1'b1;
            mut_wr_data = '0;
            cov_wr_data = '0;
        end
        else
        begin
            wr_addr     = pend_addr_reg;
            mut_wr_en   = pend_valid_reg && pend_mut_reg;
            cov_wr_en   = pend_valid_reg && !pend_mut_reg;
            mut_wr_data = (mut_rd_data == '1) ? mut_rd_data
                                              : mut_rd_data + COUNT_BITS'(1);
            cov_wr_data = (cov_rd_data == '1) ? cov_rd_data
                                              : cov_rd_data + COUNT_BITS'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_SWEEP;
            cnt_reg        <= '0;
            init_done_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            init_done_reg  <= init_done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pend_mut_reg  <= pend_mut_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    assign status.init_done = init_done_reg;
    assign result.valid     = out_valid_reg;
    assign result.payload   = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mutation_and_coverage_histogram.sv
// A readout passes through the queue and the back-end IDLE, READ and OUT states, and waits
// in OUT until the output register is free. A coverage range steps through its clipped
// positions, then drains; a mutation passes MUT and DRAIN; a clear sweeps one entry a cycle.
// A two-entry queue lets the front accept beats while the back end works.
// Reset: a clearing pass over all MAX_POSITIONS entries zeroes both stores; item.ready stays low
// until it ends, while length writes are taken at all times.
// ---------------------------------------------------------------------------
// mutation_and_coverage_histogram
// Per-position mutation and coverage counters with range increment.
// ---------------------------------------------------------------------------
`default_nettype none

module mutation_and_coverage_histogram #(
    parameter int MAX_POSITIONS = 4096,
    parameter int COUNT_BITS    = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    mch_stream_if.sink   item,
    mch_stream_if.source result,
    mch_stream_if.sink   cfg
);
    import mch_pkg::*;

    logic         push;
    op_t          push_op;
    logic         queue_full;
    logic         queue_empty;
    logic         pop;
    op_t          head_op;
    back_status_t status;

    // Accept and classify.
    mch_front #(.MAX_POSITIONS(MAX_POSITIONS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .status     (status),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    // Decoupling queue.
    mch_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (queue_empty)
    );

    // Execute on the counter stores.
    mch_back #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_op     (head_op),
        .queue_empty (queue_empty),
        .pop         (pop),
        .status      (status),
        .result      (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mch_checker.sv
// ---------------------------------------------------------------------------
// mch_checker
// Port-level checks of the coverage histogram, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mch_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_ready,
    input wire logic [1:0]           item_command,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire mch_pkg::result_t     result_payload
);
    import mch_pkg::*;

    logic       readout_beat;
    logic       result_beat;
    logic [2:0] pending_reg, pending_next;

    assign readout_beat = item_valid && item_ready && (cmd_t'(item_command) == CMD_READOUT);
    assign result_beat  = result_valid && result_ready;

    // Readouts accepted whose result has not been delivered yet.
    always_comb
    begin
        pending_next = pending_reg;
        if (readout_beat && !result_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (result_beat && !readout_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result beat holds.
    `MCH_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_payload), "result beat changed while stalled")

    // Every result answers an accepted readout.
    `MCH_ASSERT_SAME(a_result_has_readout, result_valid, pending_reg != 3'd0, "result without a pending readout")

    // Backpressure bounds the readouts in flight to queue, back end and output register.
    `MCH_ASSERT_SAME(a_pending_bound, 1'b1, pending_reg <= 3'd4, "too many readouts in flight")

endmodule

bind mutation_and_coverage_histogram mch_checker u_mch_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_command   (item.payload.command),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

`default_nettype wire

FILE: dv/mutation_and_coverage_histogram_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mutation_and_coverage_histogram_tb
// Self-checking bench for the coverage histogram. A queue of command beats
// feeds a randomly idling driver. Every accepted beat also updates a local
// copy of both counter stores. Readout results are compared field by field
// against the expected readouts, in order. The run steps through several
// sequence lengths, with the stream idle before each length write.
// ---------------------------------------------------------------------------
`default_nettype none

module mutation_and_coverage_histogram_tb;

    import mch_pkg::*;

    localparam int MAX_POSITIONS = 4096;
    localparam int COUNT_BITS    = 32;
    localparam int PHASE_COUNT   = 6;
    // Worst back-end backlog: two queued clears or full ranges plus one in flight.
    localparam int SETTLE_CYCLES = 3 * (MAX_POSITIONS + 2) + 16;
    localparam int STALL_LIMIT   = 60000;
    localparam int MAX_REPORTS   = 10;

    logic clk;
    logic rst_n;

    mch_stream_if #(.payload_t(item_t))             item_ch ();
    mch_stream_if #(.payload_t(result_t))           result_ch ();
    mch_stream_if #(.payload_t(logic [LEN_W-1:0])) cfg_ch ();

    mutation_and_coverage_histogram #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .COUNT_BITS    (COUNT_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Local copy of the block's state.
    logic [COUNT_BITS-1:0] mutation_hist [MAX_POSITIONS];
    logic [COUNT_BITS-1:0] coverage_hist [MAX_POSITIONS];
    logic [LEN_W-1:0]      length_reg;

    item_t   pending_beats[$];
    result_t expected_readouts[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned stall_cycles;

    // Clock generation.
    always #6 clk = ~clk;

    // Log a failure; only the first few get printed.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Apply one accepted command beat to the local stores and queue the readout, if any.
    task automatic apply_beat(input item_t beat);
        int       in_use;
        int       stop;
        result_t  readout;
        in_use = (length_reg > MAX_POSITIONS) ? MAX_POSITIONS : int'(length_reg);
        case (cmd_t'(beat.command))
            CMD_CLEAR:
            begin
                for (int i = 0; i < MAX_POSITIONS; i++)
                begin
                    mutation_hist[i] = '0;
                    coverage_hist[i] = '0;
                end
            end
            CMD_RANGE:
            begin
                stop = (int'(beat.range_end) > in_use) ? in_use : int'(beat.range_end);
                for (int i = int'(beat.position); i < stop; i++)
                begin
                    if (coverage_hist[i] != '1)
                        coverage_hist[i] = coverage_hist[i] + 1'b1;
                end
            end
            CMD_MUTATION:
            begin
                if (int'(beat.position) < in_use && mutation_hist[beat.position] != '1)
                    mutation_hist[beat.position] = mutation_hist[beat.position] + 1'b1;
            end
            default:
            begin
                readout.read_position = beat.position;
                if (int'(beat.position) < in_use)
                begin
                    readout.mutation_count = OUT_CNT_W'(mutation_hist[beat.position]);
                    readout.coverage_count = OUT_CNT_W'(coverage_hist[beat.position]);
                end
                else
                begin
                    readout.mutation_count = '0;
                    readout.coverage_count = '0;
                end
                expected_readouts.push_back(readout);
            end
        endcase
    endtask

    function automatic item_t make_beat(input cmd_t cmd, input int pos, input int stop);
        item_t beat;
        beat.command   = cmd;
        beat.position  = POS_W'(pos);
        beat.range_end = LEN_W'(stop);
        return beat;
    endfunction

    // Random beat: positions cluster in a window so counts build up, with some
    // picks around the length boundary and some anywhere.
    function automatic item_t random_beat(input int in_use, input int base);
        int unsigned roll;
        int          pos;
        int          stop;
        cmd_t        cmd;
        roll = $urandom_range(99);
        if (roll < 1)
            cmd = CMD_CLEAR;
        else if (roll < 36)
            cmd = CMD_RANGE;
        else if (roll < 66)
            cmd = CMD_MUTATION;
        else
            cmd = CMD_READOUT;
        roll = $urandom_range(99);
        if (roll < 70)
            pos = base + int'($urandom_range(63));
        else if (roll < 85)
            pos = in_use - 2 + int'($urandom_range(4));
        else
            pos = int'($urandom_range(MAX_POSITIONS - 1));
        if (pos < 0)
            pos = 0;
        if (pos > MAX_POSITIONS - 1)
            pos = MAX_POSITIONS - 1;
        roll = $urandom_range(99);
        if (roll < 80)
            stop = pos + int'($urandom_range(300));
        else if (roll < 90)
            stop = int'($urandom_range(8191));
        else
            stop = int'($urandom_range(pos));
        return make_beat(cmd, pos, stop);
    endfunction

    // Driver: offer the next pending beat, idling at random; predict on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.payload <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                apply_beat(item_ch.payload);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_ch.valid   <= 1'b1;
                    item_ch.payload <= pending_beats.pop_front();
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure and in-order comparison of readout beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_readouts.size() == 0)
                begin
                    report_error($sformatf("unexpected readout of position %0d",
                                           result_ch.payload.read_position));
                end
                else
                begin
                    result_t want;
                    want = expected_readouts.pop_front();
                    if (result_ch.payload.read_position !== want.read_position)
                        report_error($sformatf("read_position exp %0d got %0d",
                                               want.read_position,
                                               result_ch.payload.read_position));
                    if (result_ch.payload.mutation_count !== want.mutation_count)
                        report_error($sformatf("pos %0d mutation_count exp %0d got %0d",
                                               want.read_position, want.mutation_count,
                                               result_ch.payload.mutation_count));
                    if (result_ch.payload.coverage_count !== want.coverage_count)
                        report_error($sformatf("pos %0d coverage_count exp %0d got %0d",
                                               want.read_position, want.coverage_count,
                                               result_ch.payload.coverage_count));
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", stall_cycles);
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Write the sequence length register; the block must be idle.
    task automatic write_length(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        length_reg = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold off until every queued beat is taken and every readout has come back,
    // then let the back end finish any trailing clear or range.
    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || item_ch.valid || expected_readouts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Directed beats: field extremes, every command and the corner cases.
    task automatic queue_directed();
        pending_beats.push_back(make_beat(CMD_READOUT, 0, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 4095, 8191));
        pending_beats.push_back(make_beat(CMD_RANGE, 0, 4096));
        pending_beats.push_back(make_beat(CMD_RANGE, 10, 5));
        pending_beats.push_back(make_beat(CMD_RANGE, 7, 7));
        pending_beats.push_back(make_beat(CMD_MUTATION, 0, 0));
        pending_beats.push_back(make_beat(CMD_MUTATION, 4095, 0));
        pending_beats.push_back(make_beat(CMD_MUTATION, 4095, 8191));
        pending_beats.push_back(make_beat(CMD_RANGE, 4000, 8191));
        pending_beats.push_back(make_beat(CMD_READOUT, 0, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 4095, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 4000, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 3999, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 7, 0));
        pending_beats.push_back(make_beat(CMD_CLEAR, 2730, 5461));
        pending_beats.push_back(make_beat(CMD_READOUT, 4095, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 0, 0));
        pending_beats.push_back(make_beat(CMD_RANGE, 4095, 4096));
        pending_beats.push_back(make_beat(CMD_MUTATION, 1365, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 4095, 0));
        pending_beats.push_back(make_beat(CMD_READOUT, 1365, 0));
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [LEN_W-1:0] lengths [PHASE_COUNT];
        int               beat_counts [PHASE_COUNT];
        int               in_use;
        int               base;

        clk             = 1'b0;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.payload  = '0;
        error_count     = 0;
        stall_cycles    = 0;
        send_idle_pct   = 32;
        recv_idle_pct   = 88;
        length_reg      = SEQ_LEN_RESET;
        for (int i = 0; i < MAX_POSITIONS; i++)
        begin
            mutation_hist[i] = '0;
            coverage_hist[i] = '0;
        end

        lengths     = '{13'd4096, 13'd1, 13'd4095, 13'd100,
                        LEN_W'($urandom_range(4094, 2)), 13'd4096};
        beat_counts = '{250, 100, 250, 250, 250, 250};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            // Idle pattern: receiver-heavy, then sender-heavy, then none.
            if (ph < 2)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 88;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            write_length(lengths[ph]);
            if (ph == 0)
                queue_directed();

            in_use = int'(lengths[ph]);
            base   = int'($urandom_range((in_use > 64) ? in_use - 64 : 0));
            for (int n = 0; n < beat_counts[ph]; n++)
                pending_beats.push_back(random_beat(in_use, base));

            wait_until_drained();
        end

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
